[hdl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int ReqW   = 3;
    localparam int PidW   = 8;
    localparam int PrioW  = 2;
    localparam int SliceW = 16;
    localparam int TickW  = 32;
    localparam int StW    = 2;
    localparam int StatW  = 2;

    localparam logic [ReqW-1:0] REQ_ADD    = 3'd0;
    localparam logic [ReqW-1:0] REQ_REMOVE = 3'd1;
    localparam logic [ReqW-1:0] REQ_TICK   = 3'd2;
    localparam logic [ReqW-1:0] REQ_YIELD  = 3'd3;
    localparam logic [ReqW-1:0] REQ_SLEEP  = 3'd4;

    localparam logic [StW-1:0] ST_READY    = 2'd0;
    localparam logic [StW-1:0] ST_RUNNING  = 2'd1;
    localparam logic [StW-1:0] ST_SLEEPING = 2'd2;

    localparam logic [StatW-1:0] STAT_OK        = 2'd0;
    localparam logic [StatW-1:0] STAT_FULL      = 2'd1;
    localparam logic [StatW-1:0] STAT_NOT_FOUND = 2'd2;

    // Packed table entry: one memory word.
    typedef struct packed {
        logic [PidW-1:0]   pid;
        logic [PrioW-1:0]  prio;
        logic [StW-1:0]    st;
        logic [SliceW-1:0] slice;
        logic [TickW-1:0]  wake;
    } entry_t;

    localparam int EntryW = $bits(entry_t);

endpackage

[hdl/priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Strict-priority, time-slice task scheduler over a task table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (tuser = req_type; tdata = pid, priority_req,
//   slice_len, now_tick, wake_tick from bit 0 up). Every request gives exactly
//   one result on m_axis (tdata = current_pid, current_valid, switched,
//   task_count, status from bit 0 up).
//   The task table lives in one single-port RAM; a sequencer walks it entry
//   by entry. One request is processed at a time.
//   Add, full table, unknown codes and tick or yield with no current task
//   go straight to the result. Sleep searches the table; remove searches it
//   and shifts the later entries down; tick and yield are paced by the
//   single RAM port (wake scan, one search pass per priority level, then
//   demote and promote writes).
//   The result sits in an output register; s_axis_tready stays low until it
//   is taken, so a stalled receiver holds the block. Reset empties the table
//   (count zero) and clears the current task; RAM content is not cleared.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
    parameter int MAX_TASKS       = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pid[7:0], priority_req[9:8], slice_len[25:10], now_tick[57:26],
    // wake_tick[89:58], zero fill to 96
    input  logic [95:0]  s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // current_pid[7:0], current_valid[8], switched[9], task_count[14:10],
    // status[16:15], zero fill to 24
    output logic [23:0]  m_axis_tdata
);
    import pts_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int LW = (PRIORITY_LEVELS > 2) ? $clog2(PRIORITY_LEVELS) : 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FIND   = 11'b00000000010,
        S_SHIFT  = 11'b00000000100,
        S_WAKE   = 11'b00000001000,
        S_PICK   = 11'b00000010000,
        S_NREAD  = 11'b00000100000,
        S_CFIND  = 11'b00001000000,
        S_DEMOTE = 11'b00010000000,
        S_PROMO  = 11'b00100000000,
        S_OUT    = 11'b01000000000,
        S_SLEEPW = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ReqW-1:0]   req_reg, req_next;
    logic [PidW-1:0]   pid_reg, pid_next;
    logic [TickW-1:0]  now_reg, now_next;
    logic [TickW-1:0]  wake_reg, wake_next;

    logic [CW-1:0]     count_reg, count_next;
    logic [PidW-1:0]   run_pid_reg, run_pid_next;
    logic              run_valid_reg, run_valid_next;
    logic [SliceW-1:0] slice_left_reg, slice_left_next;
    logic              pend_reg, pend_next;

    // scan: addr_reg is the RAM address presented; rd_idx_reg tags rdata
    logic [CW-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [LW:0]       lvl_reg, lvl_next;
    logic [AW-1:0]     pick_reg, pick_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic              cur_ok_reg, cur_ok_next;
    entry_t            hold_reg, hold_next;
    logic              sw_reg, sw_next;
    logic [StatW-1:0]  stat_reg, stat_next;
    logic              out_valid_reg, out_valid_next;
    logic [23:0]       out_data_reg, out_data_next;

    logic              we;
    logic [AW-1:0]     ram_addr;
    entry_t            wdata, rdata;

    pts_ram #(.WIDTH(EntryW), .DEPTH(MAX_TASKS)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (ram_addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    logic [AW-1:0] addr_cut;
    logic [AW-1:0] rd_cut;
    assign addr_cut = addr_reg[AW-1:0];
    assign rd_cut   = rd_idx_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        pid_next        = pid_reg;
        now_next        = now_reg;
        wake_next       = wake_reg;
        count_next      = count_reg;
        run_pid_next    = run_pid_reg;
        run_valid_next  = run_valid_reg;
        slice_left_next = slice_left_reg;
        pend_next       = pend_reg;
        addr_next       = addr_reg;
        rd_idx_next     = addr_reg;
        rd_ok_next      = 1'b0;
        lvl_next        = lvl_reg;
        pick_next       = pick_reg;
        cur_next        = cur_reg;
        cur_ok_next     = cur_ok_reg;
        hold_next       = hold_reg;
        sw_next         = sw_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        we              = 1'b0;
        ram_addr        = addr_cut;
        wdata           = rdata;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    req_next  = s_axis_tuser;
                    pid_next  = s_axis_tdata[7:0];
                    now_next  = s_axis_tdata[57:26];
                    wake_next = s_axis_tdata[89:58];
                    sw_next   = 1'b0;
                    stat_next = STAT_OK;
                    addr_next = '0;
                    rd_ok_next = 1'b0;
                    unique case (s_axis_tuser)
                        REQ_ADD:
                        begin
                            if (count_reg >= CW'(MAX_TASKS))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                we             = 1'b1;
                                ram_addr       = count_reg[AW-1:0];
                                wdata.pid      = s_axis_tdata[7:0];
                                wdata.prio     = s_axis_tdata[9:8];
                                wdata.slice    = s_axis_tdata[25:10];
                                wdata.wake     = '0;
                                wdata.st       = run_valid_reg ? ST_READY : ST_RUNNING;
                                count_next     = count_reg + 1'b1;
                                if (!run_valid_reg)
                                begin
                                    run_pid_next    = s_axis_tdata[7:0];
                                    run_valid_next  = 1'b1;
                                    slice_left_next = s_axis_tdata[25:10];
                                    sw_next         = 1'b1;
                                end
                                state_next = S_OUT;
                            end
                        end
                        REQ_REMOVE, REQ_SLEEP:
                        begin
                            state_next = S_FIND;
                        end
                        REQ_TICK, REQ_YIELD:
                        begin
                            if (s_axis_tuser == REQ_YIELD)
                            begin
                                pend_next = 1'b1;
                            end
                            state_next = run_valid_reg ? S_WAKE : S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            // Walk entries: issue read at addr_reg, check rdata of rd_idx_reg.
            S_FIND:
            begin
                rd_ok_next = addr_reg < count_reg;
                addr_next  = addr_reg + 1'b1;
                if (rd_ok_reg && rdata.pid == pid_reg)
                begin
                    if (req_reg == REQ_SLEEP)
                    begin
                        we         = 1'b1;
                        ram_addr   = rd_cut;
                        wdata.st   = ST_SLEEPING;
                        wdata.wake = wake_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // shift: read i+1, write i
                        pick_next  = rd_cut;
                        addr_next  = rd_idx_reg + 1'b1;
                        rd_ok_next = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
                else if (addr_reg > count_reg)
                begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = S_OUT;
                end
            end

            S_SHIFT:
            begin
                // addr_reg = pick+1; read it, then write to pick next cycle
                if (!rd_ok_reg)
                begin
                    if (addr_reg >= count_reg || addr_reg >= CW'(MAX_TASKS))
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                    end
                end
                else
                begin
                    we         = 1'b1;
                    ram_addr   = pick_reg;
                    wdata      = rdata;
                    pick_next  = pick_reg + 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    rd_ok_next = 1'b0;
                end
            end

            // Wake scan: read i, write back next cycle if it wakes.
            S_WAKE:
            begin
                if (rd_ok_reg)
                begin
                    if (rdata.st == ST_SLEEPING && now_reg >= rdata.wake)
                    begin
                        we       = 1'b1;
                        ram_addr = rd_cut;
                        wdata.st = ST_READY;
                    end
                    rd_ok_next = 1'b0;
                    addr_next  = rd_idx_reg + 1'b1;
                end
                else if (addr_reg < count_reg)
                begin
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    addr_next = '0;
                    if (run_pid_reg == '0)
                    begin
                        state_next = S_PICK;
                    end
                    else
                    begin
                        if (slice_left_reg > 1'b0)
                        begin
                            slice_left_next = slice_left_reg - 1'b1;
                        end
                        if (slice_left_reg <= SliceW'(1) || pend_reg)
                        begin
                            pend_next  = 1'b0;
                            state_next = S_PICK;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    lvl_next  = (LW+1)'(PRIORITY_LEVELS - 1);
                    pick_next = '0;
                    if (count_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            // One pass per level, from the highest down; entry 0 if none is ready or the table holds one task.
            S_PICK:
            begin
                rd_ok_next = addr_reg < count_reg;
                addr_next  = addr_reg + 1'b1;
                if (count_reg <= CW'(1))
                begin
                    pick_next  = '0;
                    addr_next  = '0;
                    state_next = S_NREAD;
                end
                else if (rd_ok_reg && rdata.st == ST_READY
                         && rdata.prio == PrioW'(lvl_reg))
                begin
                    pick_next  = rd_cut;
                    addr_next  = CW'(rd_cut);
                    state_next = S_NREAD;
                end
                else if (addr_reg > count_reg)
                begin
                    addr_next  = '0;
                    rd_ok_next = 1'b0;
                    if (lvl_reg == '0)
                    begin
                        pick_next  = '0;
                        state_next = S_NREAD;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - 1'b1;
                    end
                end
            end

            S_NREAD:
            begin
                // address = pick; rdata valid next cycle
                ram_addr   = pick_reg;
                rd_ok_next = 1'b1;
                if (rd_ok_reg && rd_idx_reg == CW'(pick_reg))
                begin
                    hold_next = rdata;
                    if (run_valid_reg && rdata.pid == run_pid_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        addr_next   = '0;
                        rd_ok_next  = 1'b0;
                        cur_ok_next = 1'b0;
                        state_next  = S_CFIND;
                    end
                end
                else
                begin
                    rd_idx_next = CW'(pick_reg);
                end
            end

            S_CFIND:
            begin
                rd_ok_next = addr_reg < count_reg;
                addr_next  = addr_reg + 1'b1;
                if (rd_ok_reg && rdata.pid == run_pid_reg)
                begin
                    cur_next    = rd_cut;
                    cur_ok_next = rdata.st == ST_RUNNING;
                    state_next  = S_DEMOTE;
                end
                else if (addr_reg > count_reg)
                begin
                    state_next = S_PROMO;
                end
            end

            S_DEMOTE:
            begin
                if (cur_ok_reg)
                begin
                    // re-read entry cur; written back in the next state
                    ram_addr = cur_reg;
                end
                state_next = S_SLEEPW;
            end

            S_SLEEPW:
            begin
                ram_addr = cur_reg;
                if (cur_ok_reg)
                begin
                    we       = 1'b1;
                    wdata.st = ST_READY;
                end
                state_next = S_PROMO;
            end

            S_PROMO:
            begin
                we              = 1'b1;
                ram_addr        = pick_reg;
                wdata           = hold_reg;
                wdata.st        = ST_RUNNING;
                slice_left_next = hold_reg.slice;
                run_pid_next    = hold_reg.pid;
                run_valid_next  = 1'b1;
                sw_next         = 1'b1;
                state_next      = S_OUT;
            end

            S_OUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {7'd0, stat_reg, 5'(count_reg), sw_reg, run_valid_reg,
                                  run_valid_reg ? run_pid_reg : 8'd0};
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            run_pid_reg    <= '0;
            run_valid_reg  <= 1'b0;
            slice_left_reg <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            run_pid_reg    <= run_pid_next;
            run_valid_reg  <= run_valid_next;
            slice_left_reg <= slice_left_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            rd_ok_reg      <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pid_reg      <= pid_next;
        now_reg      <= now_next;
        wake_reg     <= wake_next;
        addr_reg     <= addr_next;
        rd_idx_reg   <= rd_idx_next;
        lvl_reg      <= lvl_next;
        pick_reg     <= pick_next;
        cur_reg      <= cur_next;
        cur_ok_reg   <= cur_ok_next;
        hold_reg     <= hold_next;
        sw_reg       <= sw_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("task count above capacity");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result lost under stall");

    a_switch_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROMO |=> run_valid_reg)
        else $error("switch without current task");

endmodule

[hdl/pts_ram.sv]
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-port RAM, one address per cycle, registered read (a write returns the old word).
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[test/tb_priority_task_scheduler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler
// Self-checking bench: random and directed requests go in on s_axis, a
// behavioral scheduler predicts each result, and the monitor compares the
// m_axis results in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler;
    import pts_pkg::*;

    localparam int NTASK = 16;
    localparam int NLVL  = 4;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [TickW-1:0]  wake;
        logic [TickW-1:0]  now;
        logic [SliceW-1:0] slice;
        logic [PrioW-1:0]  prio;
        logic [PidW-1:0]   pid;
        logic [ReqW-1:0]   req;
    } sched_req_t;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [4:0]       count;
        logic             sw;
        logic             cur_valid;
        logic [PidW-1:0]  cur_pid;
    } sched_res_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [2:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [23:0] m_axis_tdata;

    priority_task_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predicted scheduler state
    logic [PidW-1:0]   t_pid   [NTASK];
    logic [PrioW-1:0]  t_prio  [NTASK];
    logic [StW-1:0]    t_st    [NTASK];
    logic [SliceW-1:0] t_slice [NTASK];
    logic [TickW-1:0]  t_wake  [NTASK];
    int                n_tasks;
    logic [PidW-1:0]   run_pid;
    logic              run_valid;
    logic [SliceW-1:0] slice_left;
    logic              yield_pending;

    sched_req_t pending_reqs[$];
    sched_res_t expected_results[$];
    int errors;
    int cycles;
    bit hold_sender;
    int sink_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_task(logic [PidW-1:0] p);
        for (int i = 0; i < n_tasks; i++)
            if (t_pid[i] == p) return i;
        return -1;
    endfunction

    function automatic int choose_task();
        if (n_tasks == 0) return -1;
        if (n_tasks == 1) return 0;
        for (int l = NLVL - 1; l >= 0; l--)
            for (int i = 0; i < n_tasks; i++)
                if (t_st[i] == ST_READY && t_prio[i] == l) return i;
        return 0;
    endfunction

    function automatic bit switch_task();
        int n;
        int c;
        n = choose_task();
        if (n < 0) return 1'b0;
        if (run_valid && t_pid[n] == run_pid) return 1'b0;
        if (run_valid)
        begin
            c = find_task(run_pid);
            if (c >= 0 && t_st[c] == ST_RUNNING) t_st[c] = ST_READY;
        end
        t_st[n] = ST_RUNNING;
        slice_left = t_slice[n];
        run_pid = t_pid[n];
        run_valid = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit timer_tick(logic [TickW-1:0] now);
        if (!run_valid) return 1'b0;
        for (int i = 0; i < n_tasks; i++)
            if (t_st[i] == ST_SLEEPING && now >= t_wake[i]) t_st[i] = ST_READY;
        if (run_pid == 0) return switch_task();
        if (slice_left > 0) slice_left--;
        if (slice_left == 0) yield_pending = 1'b1;
        if (yield_pending)
        begin
            yield_pending = 1'b0;
            return switch_task();
        end
        return 1'b0;
    endfunction

    function automatic sched_res_t schedule(sched_req_t r);
        sched_res_t res;
        int idx;
        res = '0;
        case (r.req)
            REQ_ADD:
                if (n_tasks >= NTASK) res.status = STAT_FULL;
                else
                begin
                    t_pid[n_tasks] = r.pid;
                    t_prio[n_tasks] = r.prio;
                    t_slice[n_tasks] = r.slice;
                    t_wake[n_tasks] = '0;
                    t_st[n_tasks] = ST_READY;
                    if (!run_valid)
                    begin
                        t_st[n_tasks] = ST_RUNNING;
                        run_pid = r.pid;
                        run_valid = 1'b1;
                        slice_left = r.slice;
                        res.sw = 1'b1;
                    end
                    n_tasks++;
                end
            REQ_REMOVE:
            begin
                idx = find_task(r.pid);
                if (idx < 0) res.status = STAT_NOT_FOUND;
                else
                begin
                    for (int i = idx; i + 1 < n_tasks; i++)
                    begin
                        t_pid[i] = t_pid[i+1];
                        t_prio[i] = t_prio[i+1];
                        t_st[i] = t_st[i+1];
                        t_slice[i] = t_slice[i+1];
                        t_wake[i] = t_wake[i+1];
                    end
                    n_tasks--;
                end
            end
            REQ_TICK: res.sw = timer_tick(r.now);
            REQ_YIELD:
            begin
                yield_pending = 1'b1;
                res.sw = timer_tick(r.now);
            end
            REQ_SLEEP:
            begin
                idx = find_task(r.pid);
                if (idx < 0) res.status = STAT_NOT_FOUND;
                else
                begin
                    t_st[idx] = ST_SLEEPING;
                    t_wake[idx] = r.wake;
                end
            end
            default: ;
        endcase
        res.cur_pid = run_valid ? run_pid : '0;
        res.cur_valid = run_valid;
        res.count = n_tasks[4:0];
        return res;
    endfunction

    function automatic sched_req_t make_req(logic [ReqW-1:0] k, logic [PidW-1:0] p,
                                            logic [PrioW-1:0] pr, logic [SliceW-1:0] s,
                                            logic [TickW-1:0] nw, logic [TickW-1:0] wk);
        sched_req_t r;
        r.req = k; r.pid = p; r.prio = pr; r.slice = s; r.now = nw; r.wake = wk;
        return r;
    endfunction

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 55) return 0;
        if (g < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // random request, mostly small pids so that lookups hit
    function automatic sched_req_t rand_req(logic [TickW-1:0] nw);
        int k;
        logic [PidW-1:0] p;
        logic [SliceW-1:0] s;
        k = $urandom_range(0, 99);
        p = ($urandom_range(0, 9) == 0) ? PidW'($urandom) : PidW'($urandom_range(0, 12));
        s = ($urandom_range(0, 9) == 0) ? SliceW'($urandom) : SliceW'($urandom_range(0, 5));
        if (k < 25) return make_req(REQ_ADD, p, PrioW'($urandom), s, $urandom, $urandom);
        if (k < 37) return make_req(REQ_REMOVE, p, PrioW'($urandom), s, $urandom, $urandom);
        if (k < 70) return make_req(REQ_TICK, p, PrioW'($urandom), s, nw, $urandom);
        if (k < 82) return make_req(REQ_YIELD, p, PrioW'($urandom), s, nw, $urandom);
        if (k < 97)
            return make_req(REQ_SLEEP, p, PrioW'($urandom), s, $urandom,
                            ($urandom_range(0, 4) == 0) ? $urandom : nw + $urandom_range(0, 20));
        return make_req(ReqW'($urandom_range(5, 7)), PidW'($urandom), PrioW'($urandom),
                        SliceW'($urandom), $urandom, $urandom);
    endfunction

    // driver
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin
        sched_req_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            src_gap <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_results.push_back(
                    schedule(sched_req_t'({s_axis_tdata[89:0], s_axis_tuser})));
            if (src_gap > 0 || hold_sender || pending_reqs.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (src_gap > 0) src_gap <= src_gap - 1;
            end
            else
            begin
                nxt = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= nxt.req;
                s_axis_tdata <= {6'b000000, nxt.wake, nxt.now, nxt.slice, nxt.prio, nxt.pid};
                src_gap <= gap_len();
            end
        end
    end

    // long receiver stall, counted down here
    always @(posedge clk)
    begin
        if (sink_hold_cycles > 0) sink_hold_cycles <= sink_hold_cycles - 1;
    end

    // monitor
    int sink_gap;
    always @(posedge clk or negedge rst_n)
    begin
        sched_res_t got;
        sched_res_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = sched_res_t'(m_axis_tdata[16:0]);
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want || m_axis_tdata[23:17] !== '0)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: pid %0d/%0d valid %0d/%0d sw %0d/%0d cnt %0d/%0d st %0d/%0d (exp/act)",
                                     want.cur_pid, got.cur_pid, want.cur_valid, got.cur_valid,
                                     want.sw, got.sw, want.count, got.count,
                                     want.status, got.status);
                    end
                end
            end
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready) sink_gap <= gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [TickW-1:0] nw;
        errors = 0;
        cycles = 0;
        hold_sender = 1'b0;
        sink_hold_cycles = 0;
        n_tasks = 0;
        run_pid = '0;
        run_valid = 1'b0;
        slice_left = '0;
        yield_pending = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no current task, first add, idle task, duplicates, full, misses
        pending_reqs.push_back(make_req(REQ_TICK, 8'd0, 2'd0, 16'd0, 32'd5, 32'd0));
        pending_reqs.push_back(make_req(REQ_YIELD, 8'd0, 2'd0, 16'd0, 32'd6, 32'd0));
        pending_reqs.push_back(make_req(REQ_REMOVE, 8'd9, 2'd0, 16'd0, 32'd0, 32'd0));
        pending_reqs.push_back(make_req(REQ_ADD, 8'd0, 2'd0, 16'd0, 32'd0, 32'd0));
        pending_reqs.push_back(make_req(REQ_ADD, 8'd255, 2'd3, 16'hFFFF, 32'd0, 32'd0));
        pending_reqs.push_back(make_req(REQ_ADD, 8'd255, 2'd1, 16'd1, 32'd0, 32'd0));
        pending_reqs.push_back(make_req(REQ_TICK, 8'd0, 2'd0, 16'd0, 32'hFFFFFFFF, 32'd0));
        pending_reqs.push_back(make_req(REQ_SLEEP, 8'd255, 2'd0, 16'd0, 32'd0, 32'hFFFFFFFF));
        pending_reqs.push_back(make_req(REQ_SLEEP, 8'd77, 2'd0, 16'd0, 32'd0, 32'd3));
        pending_reqs.push_back(make_req(REQ_YIELD, 8'd0, 2'd0, 16'd0, 32'd10, 32'd0));
        pending_reqs.push_back(make_req(REQ_TICK, 8'd0, 2'd0, 16'd0, 32'hFFFFFFFF, 32'd0));
        pending_reqs.push_back(make_req(REQ_REMOVE, 8'd255, 2'd0, 16'd0, 32'd0, 32'd0));
        pending_reqs.push_back(make_req(3'd5, 8'hAA, 2'd2, 16'h5555, 32'h5555AAAA, 32'hAAAA5555));
        pending_reqs.push_back(make_req(3'd7, 8'h55, 2'd1, 16'hAAAA, 32'hAAAA5555, 32'h5555AAAA));
        for (int i = 0; i < 17; i++)
            pending_reqs.push_back(make_req(REQ_ADD, PidW'(i + 1), PrioW'(i), 16'd2, 32'd0, 32'd0));
        wait_drained();

        // long receiver stall while the sender keeps offering
        sink_hold_cycles = 300;
        nw = 32'd100;
        for (int i = 0; i < 40; i++)
        begin
            nw += $urandom_range(0, 2);
            pending_reqs.push_back(rand_req(nw));
        end
        wait_drained();

        for (int b = 0; b < 14; b++)
        begin
            for (int i = 0; i < 100; i++)
            begin
                nw += $urandom_range(0, 2);
                pending_reqs.push_back(rand_req(nw));
            end
            while (pending_reqs.size() > 10) @(posedge clk);
        end
        wait_drained();
        repeat (150) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
